[design/char_lcd_parallel_write_sequencer_core_defines.svh]
// Assertion macros shared by the sequencer RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef CHAR_LCD_PARALLEL_WRITE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_PARALLEL_WRITE_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Concurrent check on an explicit clock and active-low reset.
`define CLPWS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the block's own clock and reset.
`define CLPWS_ASSERT(lbl, prop, msg) `CLPWS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CLPWS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CLPWS_ASSERT(lbl, prop, msg)
`endif

`endif

[design/clpws_pkg.sv]
package clpws_pkg;

  // Field widths of the stream words.
  localparam int unsigned ValueW   = 32;
  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HoldW    = 24;
  localparam int unsigned OutPadW  = 6;
  localparam int unsigned OutDataW = ByteW + 2 + HoldW + OutPadW;
  localparam int unsigned CfgIdxW  = 3;

  // Bit positions inside the output tdata.
  localparam int unsigned OutRsBit = ByteW;
  localparam int unsigned OutEnBit = ByteW + 1;

  localparam int unsigned NumberWidthDefault = 32;

  // Register reset values.
  localparam logic [HoldW-1:0] PulseWaitReset     = 24'd240;
  localparam logic [HoldW-1:0] SettleWaitReset    = 24'd1600;
  localparam logic [HoldW-1:0] ClearWaitReset     = 24'd64000;
  localparam logic [HoldW-1:0] PowerOnWaitReset   = 24'd600000;
  localparam logic [HoldW-1:0] FirstWakeWaitReset = 24'd200000;
  localparam logic [HoldW-1:0] LaterWakeWaitReset = 24'd6400;

  // LCD command bytes.
  localparam logic [ByteW-1:0] CmdWake    = 8'h30;
  localparam logic [ByteW-1:0] CmdFuncSet = 8'h38;
  localparam logic [ByteW-1:0] CmdCursor  = 8'h10;
  localparam logic [ByteW-1:0] CmdDisplay = 8'h0C;
  localparam logic [ByteW-1:0] CmdEntry   = 8'h06;
  localparam logic [ByteW-1:0] CmdClear   = 8'h01;
  localparam logic [ByteW-1:0] CmdHome    = 8'h02;
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;

  // Fixed write sequences: power-up at the start, clear-and-home at the end.
  localparam int unsigned SeqIdxW = 4;
  localparam logic [SeqIdxW-1:0] SeqInitIdx  = 4'd0;
  localparam logic [SeqIdxW-1:0] SeqClearIdx = 4'd8;

  typedef enum logic [OpW-1:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CHAR   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_NUMBER = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE  = 3'd0,
    CFG_SETTLE = 3'd1,
    CFG_CLEAR  = 3'd2,
    CFG_POWER  = 3'd3,
    CFG_FIRST  = 3'd4,
    CFG_LATER  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    HOLD_NONE   = 3'd0,
    HOLD_PULSE  = 3'd1,
    HOLD_SETTLE = 3'd2,
    HOLD_CLEAR  = 3'd3,
    HOLD_POWER  = 3'd4,
    HOLD_FIRST  = 3'd5,
    HOLD_LATER  = 3'd6
  } hold_sel_e;

  typedef enum logic [1:0] {
    BSRC_VALUE = 2'd0,
    BSRC_SEQ   = 2'd1,
    BSRC_DIGIT = 2'd2
  } byte_src_e;

  // One entry of a fixed sequence: a byte write followed by an optional wait, or a wait alone.
  typedef struct packed {
    logic [ByteW-1:0] wr_byte;
    hold_sel_e        wait_sel;
    logic             wait_only;
    logic             last;
  } seq_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load_num;
    logic             conv_step;
    logic             digit_shift;
    logic             load_byte;
    byte_src_e        byte_src;
    logic [ByteW-1:0] seq_byte;
    logic             rs;
    logic             emit;
    logic             en;
    hold_sel_e        hold_sel;
    logic             last;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic top_zero;
  } dp_sts_t;

  function automatic seq_entry_t seq_entry(logic [SeqIdxW-1:0] idx);
    seq_entry_t e;
    e = '{wr_byte: '0, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b0};
    unique case (idx)
      4'd0: e = '{wr_byte: '0, wait_sel: HOLD_POWER, wait_only: 1'b1, last: 1'b0};
      4'd1: e = '{wr_byte: CmdWake, wait_sel: HOLD_FIRST, wait_only: 1'b0, last: 1'b0};
      4'd2: e = '{wr_byte: CmdWake, wait_sel: HOLD_LATER, wait_only: 1'b0, last: 1'b0};
      4'd3: e = '{wr_byte: CmdWake, wait_sel: HOLD_LATER, wait_only: 1'b0, last: 1'b0};
      4'd4: e = '{wr_byte: CmdFuncSet, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b0};
      4'd5: e = '{wr_byte: CmdCursor, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b0};
      4'd6: e = '{wr_byte: CmdDisplay, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b0};
      4'd7: e = '{wr_byte: CmdEntry, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b1};
      4'd8: e = '{wr_byte: CmdClear, wait_sel: HOLD_CLEAR, wait_only: 1'b0, last: 1'b0};
      4'd9: e = '{wr_byte: CmdHome, wait_sel: HOLD_CLEAR, wait_only: 1'b0, last: 1'b1};
      default: e = '{wr_byte: '0, wait_sel: HOLD_NONE, wait_only: 1'b0, last: 1'b1};
    endcase
    return e;
  endfunction

endpackage

[design/clpws_dp.sv]
module clpws_dp #(
  parameter int unsigned NUMBER_WIDTH = clpws_pkg::NumberWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clpws_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [clpws_pkg::HoldW-1:0]         cfg_data_i,
  input  logic [clpws_pkg::ValueW-1:0]        s_data_i,
  input  clpws_pkg::dp_cmd_t                  cmd_i,
  output clpws_pkg::dp_sts_t                  sts_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [clpws_pkg::OutDataW-1:0]      m_data_o,
  output logic                                m_last_o
);

  localparam int unsigned NumW    = (NUMBER_WIDTH < clpws_pkg::ValueW) ?
                                    NUMBER_WIDTH : clpws_pkg::ValueW;
  localparam int unsigned DigitsW = NumW * 30103 / 100000 + 1;
  localparam int unsigned BcdW    = 4 * DigitsW;

  logic [clpws_pkg::HoldW-1:0] pulse_q, settle_q, clear_q, power_q, first_q, later_q;
  logic [clpws_pkg::ByteW-1:0] bus_q, bus_d;
  logic                        rs_q;
  logic [NumW-1:0]             num_q, num_d;
  logic [BcdW-1:0]             bcd_q, bcd_d, bcd_adj;
  logic [3:0]                  top_digit;
  logic [clpws_pkg::HoldW-1:0] hold;
  logic                        out_valid_q;
  logic [clpws_pkg::OutDataW-1:0] out_data_q;
  logic                        out_last_q;

  // Timing registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q  <= clpws_pkg::PulseWaitReset;
      settle_q <= clpws_pkg::SettleWaitReset;
      clear_q  <= clpws_pkg::ClearWaitReset;
      power_q  <= clpws_pkg::PowerOnWaitReset;
      first_q  <= clpws_pkg::FirstWakeWaitReset;
      later_q  <= clpws_pkg::LaterWakeWaitReset;
    end else if (cfg_we_i) begin
      unique case (clpws_pkg::cfg_idx_e'(cfg_idx_i))
        clpws_pkg::CFG_PULSE:  pulse_q  <= cfg_data_i;
        clpws_pkg::CFG_SETTLE: settle_q <= cfg_data_i;
        clpws_pkg::CFG_CLEAR:  clear_q  <= cfg_data_i;
        clpws_pkg::CFG_POWER:  power_q  <= cfg_data_i;
        clpws_pkg::CFG_FIRST:  first_q  <= cfg_data_i;
        clpws_pkg::CFG_LATER:  later_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Double-dabble adjust: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < DigitsW; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  assign top_digit = bcd_q[BcdW-1 -: 4];

  // Number conversion and digit shifting.
  always_comb begin
    num_d = num_q;
    bcd_d = bcd_q;
    if (cmd_i.load_num) begin
      num_d = s_data_i[NumW-1:0];
      bcd_d = '0;
    end else if (cmd_i.conv_step) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], num_q[NumW-1]};
    end else if (cmd_i.digit_shift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  // Byte presented on the bus for the current write.
  always_comb begin
    bus_d = bus_q;
    if (cmd_i.load_byte) begin
      unique case (cmd_i.byte_src)
        clpws_pkg::BSRC_VALUE: bus_d = s_data_i[clpws_pkg::ByteW-1:0];
        clpws_pkg::BSRC_SEQ:   bus_d = cmd_i.seq_byte;
        clpws_pkg::BSRC_DIGIT: bus_d = clpws_pkg::AsciiZero + {4'd0, top_digit};
        default:               bus_d = cmd_i.seq_byte;
      endcase
    end
  end

  // Hold count of the phase being issued.
  always_comb begin
    unique case (cmd_i.hold_sel)
      clpws_pkg::HOLD_PULSE:  hold = pulse_q;
      clpws_pkg::HOLD_SETTLE: hold = settle_q;
      clpws_pkg::HOLD_CLEAR:  hold = clear_q;
      clpws_pkg::HOLD_POWER:  hold = power_q;
      clpws_pkg::HOLD_FIRST:  hold = first_q;
      clpws_pkg::HOLD_LATER:  hold = later_q;
      default:                hold = '0;
    endcase
  end

  // Working registers; these carry payload only.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    bcd_q <= bcd_d;
    bus_q <= bus_d;
    if (cmd_i.load_byte) begin
      rs_q <= cmd_i.rs;
    end
  end

  // Output register: a phase word waits here until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {{clpws_pkg::OutPadW{1'b0}}, hold, cmd_i.en, rs_q, bus_q};
      out_last_q <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_q || m_ready_i;
  assign sts_o.top_zero = (top_digit == 4'd0);

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

[design/clpws_ctrl.sv]
module clpws_ctrl #(
  parameter int unsigned NUMBER_WIDTH = clpws_pkg::NumberWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic [clpws_pkg::OpW-1:0]   s_opcode_i,
  output logic                        s_ready_o,
  input  clpws_pkg::dp_sts_t          sts_i,
  output clpws_pkg::dp_cmd_t          cmd_o
);

  localparam int unsigned NumW    = (NUMBER_WIDTH < clpws_pkg::ValueW) ?
                                    NUMBER_WIDTH : clpws_pkg::ValueW;
  localparam int unsigned DigitsW = NumW * 30103 / 100000 + 1;
  localparam int unsigned CntW    = $clog2(NumW);
  localparam int unsigned DigCntW = $clog2(DigitsW + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CONV  = 2'd1,
    S_SKIP  = 2'd2,
    S_PHASE = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    K_SINGLE = 2'd0,
    K_SEQ    = 2'd1,
    K_NUMBER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_HIGH   = 2'd1,
    PH_SETTLE = 2'd2,
    PH_WAIT   = 2'd3
  } phase_e;

  state_e                         state_q, state_d;
  kind_e                          kind_q, kind_d;
  phase_e                         ph_q, ph_d;
  clpws_pkg::hold_sel_e           wait_q, wait_d;
  logic [clpws_pkg::SeqIdxW-1:0]  idx_q, idx_d, seq_ld_idx;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [DigCntW-1:0]             dleft_q, dleft_d;
  clpws_pkg::seq_entry_t          entry_cur, entry_ld;
  logic                           seq_load, digit_load, write_end, more;

  assign s_ready_o = (state_q == S_IDLE);

  // Sequence table lookups: the current entry and the one to load next.
  always_comb begin
    if (state_q == S_IDLE) begin
      seq_ld_idx = (s_opcode_i == clpws_pkg::OP_CLEAR) ? clpws_pkg::SeqClearIdx
                                                       : clpws_pkg::SeqInitIdx;
    end else begin
      seq_ld_idx = idx_q + clpws_pkg::SeqIdxW'(1);
    end
    entry_cur = clpws_pkg::seq_entry(idx_q);
    entry_ld  = clpws_pkg::seq_entry(seq_ld_idx);
  end

  // Next-state and command logic.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    ph_d       = ph_q;
    wait_d     = wait_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    dleft_d    = dleft_q;
    cmd_o      = '0;
    seq_load   = 1'b0;
    digit_load = 1'b0;
    write_end  = 1'b0;
    more       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          unique case (clpws_pkg::opcode_e'(s_opcode_i))
            clpws_pkg::OP_INIT, clpws_pkg::OP_CLEAR: begin
              seq_load = 1'b1;
            end
            clpws_pkg::OP_CMD, clpws_pkg::OP_CHAR: begin
              cmd_o.load_byte = 1'b1;
              cmd_o.byte_src  = clpws_pkg::BSRC_VALUE;
              cmd_o.rs        = (s_opcode_i == clpws_pkg::OP_CHAR);
              wait_d          = clpws_pkg::HOLD_NONE;
              ph_d            = PH_SETUP;
              kind_d          = K_SINGLE;
              state_d         = S_PHASE;
            end
            clpws_pkg::OP_NUMBER: begin
              cmd_o.load_num = 1'b1;
              cnt_d          = CntW'(NumW - 1);
              state_d        = S_CONV;
            end
            default: ;
          endcase
        end
      end

      // One binary bit into the BCD register per cycle.
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (cnt_q == '0) begin
          dleft_d = DigCntW'(DigitsW);
          state_d = S_SKIP;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end

      // Drop leading zero digits, keeping at least one.
      S_SKIP: begin
        if (sts_i.top_zero && (dleft_q != DigCntW'(1))) begin
          cmd_o.digit_shift = 1'b1;
          dleft_d           = dleft_q - DigCntW'(1);
        end else begin
          digit_load = 1'b1;
        end
      end

      // Issue one pin phase per cycle while the output register has room.
      S_PHASE: begin
        if (sts_i.out_free) begin
          write_end = (ph_q == PH_WAIT) ||
                      ((ph_q == PH_SETTLE) && (wait_q == clpws_pkg::HOLD_NONE));
          unique case (kind_q)
            K_SEQ:    more = !entry_cur.last;
            K_NUMBER: more = (dleft_q != '0);
            default:  more = 1'b0;
          endcase
          cmd_o.emit = 1'b1;
          cmd_o.en   = (ph_q == PH_HIGH);
          cmd_o.last = write_end && !more;
          unique case (ph_q)
            PH_SETUP, PH_HIGH: cmd_o.hold_sel = clpws_pkg::HOLD_PULSE;
            PH_SETTLE:         cmd_o.hold_sel = clpws_pkg::HOLD_SETTLE;
            PH_WAIT:           cmd_o.hold_sel = wait_q;
            default:           cmd_o.hold_sel = clpws_pkg::HOLD_NONE;
          endcase
          if (!write_end) begin
            ph_d = phase_e'(ph_q + 2'd1);
          end else if (more) begin
            if (kind_q == K_SEQ) begin
              seq_load = 1'b1;
            end else begin
              digit_load = 1'b1;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Start the next write of a fixed sequence.
    if (seq_load) begin
      cmd_o.load_byte = 1'b1;
      cmd_o.byte_src  = clpws_pkg::BSRC_SEQ;
      cmd_o.seq_byte  = entry_ld.wr_byte;
      cmd_o.rs        = 1'b0;
      wait_d          = entry_ld.wait_sel;
      ph_d            = entry_ld.wait_only ? PH_WAIT : PH_SETUP;
      idx_d           = seq_ld_idx;
      kind_d          = K_SEQ;
      state_d         = S_PHASE;
    end

    // Start the write of the next decimal digit.
    if (digit_load) begin
      cmd_o.load_byte   = 1'b1;
      cmd_o.byte_src    = clpws_pkg::BSRC_DIGIT;
      cmd_o.rs          = 1'b1;
      cmd_o.digit_shift = 1'b1;
      dleft_d           = dleft_q - DigCntW'(1);
      wait_d            = clpws_pkg::HOLD_NONE;
      ph_d              = PH_SETUP;
      kind_d            = K_NUMBER;
      state_d           = S_PHASE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_SINGLE;
      ph_q    <= PH_SETUP;
      wait_q  <= clpws_pkg::HOLD_NONE;
      idx_q   <= '0;
      cnt_q   <= '0;
      dleft_q <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      ph_q    <= ph_d;
      wait_q  <= wait_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      dleft_q <= dleft_d;
    end
  end

endmodule

[design/char_lcd_parallel_write_sequencer_core.sv]
// Sequencer for an 8-bit character LCD bus. Each input word (tuser = request
// kind, tdata = value) expands into a stream of pin phases: every byte write
// is bus set with enable low, enable high, then enable low, and longer waits
// follow as separate phases that keep the pin levels. The controller issues
// one phase per clock while the sink keeps up, once the request is taken: the
// power-up sequence is 25 phases, clear-and-home 8, a single command or
// character 3. A decimal number (NUMBER_WIDTH bits, at most 32 used) first
// passes through the shift-and-add-three converter, then drops its leading
// zero digits and fetches the first digit, then takes 3 phases per digit.
// The next request is taken as soon as the final phase has entered the output
// register. Timing registers (hold counts in delay-loop units) must be written
// by the user on the cfg port only while idle; the block does not enforce it.
`include "char_lcd_parallel_write_sequencer_core_defines.svh"

module char_lcd_parallel_write_sequencer_core #(
  parameter int unsigned NUMBER_WIDTH = clpws_pkg::NumberWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request words.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [clpws_pkg::ValueW-1:0]     s_axis_tdata_i,  // value[31:0]
  input  logic [clpws_pkg::OpW-1:0]        s_axis_tuser_i,  // opcode[2:0]
  // Pin phase words.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // data_bus[7:0], register_select[8], enable_pin[9], hold_time[33:10], zero[39:34]
  output logic [clpws_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o,  // last phase of request
  // Timing register writes.
  input  logic                             cfg_we_i,
  input  logic [clpws_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [clpws_pkg::HoldW-1:0]      cfg_data_i
);

  clpws_pkg::dp_cmd_t cmd;
  clpws_pkg::dp_sts_t sts;

  clpws_ctrl #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_opcode_i (s_axis_tuser_i),
    .s_ready_o  (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clpws_dp #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_data_i   (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_last_o   (m_axis_tlast_o)
  );

  // Short names for the terms used by the checks below.
  logic                        req_taken;
  logic                        out_en;
  logic [clpws_pkg::ByteW-1:0] out_bus;

  assign req_taken = s_axis_tvalid_i && s_axis_tready_o &&
                     (s_axis_tuser_i <= clpws_pkg::OP_NUMBER);
  assign out_en    = m_axis_tdata_o[clpws_pkg::OutEnBit];
  assign out_bus   = m_axis_tdata_o[clpws_pkg::ByteW-1:0];

  // A phase is only issued when the output register can take it.
  `CLPWS_ASSERT(a_emit_has_room, cmd.emit |-> sts.out_free, "phase issued while output full")

  // A taken request with a defined opcode keeps the block busy for at least the next cycle.
  `CLPWS_ASSERT(a_busy_after_req, req_taken |=> !s_axis_tready_o, "request taken, not busy")

  // Enable only rises with the byte already set up on the bus.
  `CLPWS_ASSERT(a_bus_setup, $rose(out_en) |-> (out_bus == $past(out_bus)), "new byte at enable")

  // A request never ends with enable high.
  `CLPWS_ASSERT(a_last_en_low, (m_axis_tvalid_o && m_axis_tlast_o) |-> !out_en, "last with enable")

endmodule
